### rtl/core/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg: shared types and constants for the character LCD write sequencer
// Request and response payloads, phase and status codes, register indexes,
// register reset values and the init byte sequence.
// ----------------------------------------------------------------------------
package lcdw_pkg;

   // Configuration register map
   localparam int unsigned NUM_CFG      = 6;
   localparam int unsigned CFG_WIDTH    = 16;
   localparam int unsigned CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CFG_POWERUP_WAIT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CFG_E_HIGH_TIME    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CFG_E_LOW_TIME     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CFG_FIRST_INIT     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CFG_SECOND_INIT    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CFG_COMMAND_SETTLE = 3'd5;

   localparam logic [CFG_WIDTH-1:0] CFG_RESET [NUM_CFG] =
      '{16'd15000, 16'd50, 16'd50, 16'd5000, 16'd100, 16'd1000};

   // Init sequence: three function-set wake-ups, then four commands
   localparam logic [2:0] INIT_DONE = 3'd7;

   localparam logic [7:0] CMD_WAKE_8BIT    = 8'b0011_0000;
   localparam logic [7:0] CMD_FUNC_8BIT_2L = 8'b0011_1000;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'b0000_1100;
   localparam logic [7:0] CMD_CLEAR        = 8'b0000_0001;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'b0000_0110;
   localparam logic [7:0] CMD_SET_DDRAM    = 8'b1000_0000;
   localparam logic [7:0] ROW_OFFSET       = 8'h40;

   typedef enum logic [2:0] {
      PH_POWERUP = 3'd0,
      PH_EHIGH   = 3'd1,
      PH_ELOW    = 3'd2,
      PH_SETTLE  = 3'd3,
      PH_IDLE    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_CHAR   = 2'd1,
      REQ_CMD    = 2'd2,
      REQ_CURSOR = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_TICK     = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

   typedef struct packed {
      req_code_type req_type;
      logic [7:0]   data_byte;
      logic [5:0]   column;
      logic         row;
   } req_payload_type;

   typedef struct packed {
      logic         lcd_enable;
      logic         lcd_register_select;
      logic [7:0]   lcd_bus;
      logic         busy_res;
      status_type   request_status;
   } rsp_payload_type;

   // Byte written at each init step
   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      unique case (step) inside
         3'd0, 3'd1, 3'd2: b = CMD_WAKE_8BIT;
         3'd3:             b = CMD_FUNC_8BIT_2L;
         3'd4:             b = CMD_DISPLAY_ON;
         3'd5:             b = CMD_CLEAR;
         3'd6:             b = CMD_ENTRY_MODE;
         default:          b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### rtl/core/char_lcd_8bit_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_8bit_write_sequencer: 8-bit character LCD write sequencer
// Runs power-up and init of the display, then character, command and cursor
// writes, one tick request per cycle while the response is not stalled,
// reporting pin levels per tick.
//   port group | dir | handshake            | carries
//   req_*      | in  | req_valid/req_stall  | req_payload_type (tick/write)
//   rsp_*      | out | rsp_valid/rsp_stall  | rsp_payload_type (pins, status)
//   csr_*      | in  | csr_valid/csr_ready  | register index and 16-bit value
//
// One request per cycle sustained while rsp_stall is low; each response passes
// through the request register, then the response register; the tick step is one
// pass of compare and increment logic on the phase counter.
// Reset is synchronous and restarts the power-up wait; it is counted in ticks.
// A stalled response holds in its register while one more request is taken;
// req_stall rises only when both registers are full and rsp_stall is high.
// ----------------------------------------------------------------------------
module char_lcd_8bit_write_sequencer
   import lcdw_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_data
);

   logic                                in_valid_ff, in_valid_in;
   req_payload_type                     in_data_ff;
   logic                                out_valid_ff, out_valid_in;
   rsp_payload_type                     out_data_ff;
   rsp_payload_type                     step_rsp;
   logic [NUM_CFG-1:0][COUNTER_WIDTH-1:0] limit;
   logic                                out_adv;
   logic                                move;
   logic                                req_take;

   assign csr_ready = 1'b1;

   lcdw_csr #(.CW(COUNTER_WIDTH)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .limit    (limit)
   );

   lcdw_seq #(.CW(COUNTER_WIDTH)) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (move),
      .req     (in_data_ff),
      .limit   (limit),
      .rsp     (step_rsp)
   );

   // Pipeline control: response register frees, request register drains
   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !out_adv;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_adv ? move : out_valid_ff;
   end

   // Hold the request until the sequencer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Stall only with a request held
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("top: stall without a held request");

   // A stepped request shows up as a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid)
      else $error("top: stepped request lost");

   // A response is replaced only when taken or empty
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !move)
      else $error("top: stalled response overwritten");

endmodule

### rtl/core/lcdw_csr.sv
// ----------------------------------------------------------------------------
// lcdw_csr: timing register file
// Holds the six timing registers and presents each one clamped to the
// largest value the tick counter can reach.
// ----------------------------------------------------------------------------
module lcdw_csr
   import lcdw_pkg::*;
#(
   parameter int unsigned CW = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [CSR_IDX_BITS-1:0]        wr_index,
   input  logic [CFG_WIDTH-1:0]           wr_data,
   output logic [NUM_CFG-1:0][CW-1:0]     limit
);

   localparam int unsigned CMPW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
   localparam logic [CMPW-1:0] CMAX_W = CMPW'((64'd1 << CW) - 64'd1);

   logic [CFG_WIDTH-1:0] cfg_ff [NUM_CFG];

   // Write a register; drop writes beyond the map
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr_en && (wr_index < CSR_IDX_BITS'(NUM_CFG))) begin
         cfg_ff[wr_index] <= wr_data;
      end
   end

   // Clamp each register to the counter range
   always_comb begin
      logic [CMPW-1:0] wide;
      for (int i = 0; i < NUM_CFG; i++) begin
         wide = CMPW'(cfg_ff[i]);
         if (wide > CMAX_W) begin
            wide = CMAX_W;
         end
         limit[i] = wide[CW-1:0];
      end
   end

endmodule

### rtl/core/lcdw_seq.sv
// ----------------------------------------------------------------------------
// lcdw_seq: write sequencer state and one-tick next-state logic
// Steps the power-up, init and write phases by one tick per request, takes
// user writes when idle and forms the pin levels of the response.
// ----------------------------------------------------------------------------
module lcdw_seq
   import lcdw_pkg::*;
#(
   parameter int unsigned CW = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  req_payload_type             req,
   input  logic [NUM_CFG-1:0][CW-1:0]  limit,
   output rsp_payload_type             rsp
);

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  step;
      logic [CW-1:0] cnt;
      logic [7:0]  pend;
      logic        rs;
      logic        en;
      logic [7:0]  bus;
   } core_type;

   core_type cur_ff;
   core_type cur_in;

   function automatic core_type start_write(input core_type s, input logic [7:0] b,
                                            input logic rs);
      core_type r;
      r       = s;
      r.pend  = b;
      r.rs    = rs;
      r.phase = PH_EHIGH;
      r.cnt   = '0;
      return r;
   endfunction

   function automatic core_type count_up(input core_type s);
      core_type r;
      r = s;
      if (r.cnt != '1) begin
         r.cnt = r.cnt + CW'(1);
      end
      return r;
   endfunction

   // Leave a finished wait: start the next init write or go idle
   function automatic core_type resolve(input core_type s,
                                        input logic [NUM_CFG-1:0][CW-1:0] lim);
      core_type      r;
      logic [CW-1:0] settle;
      logic [2:0]    nstep;
      r = s;
      if (r.phase == PH_POWERUP && r.cnt >= lim[CFG_POWERUP_WAIT]) begin
         r = start_write(r, init_byte(r.step), 1'b0);
      end
      if (r.step == 3'd0) begin
         settle = lim[CFG_FIRST_INIT];
      end else if (r.step == 3'd1) begin
         settle = lim[CFG_SECOND_INIT];
      end else begin
         settle = lim[CFG_COMMAND_SETTLE];
      end
      if (r.phase == PH_SETTLE && r.cnt >= settle) begin
         nstep  = r.step + 3'd1;
         r.step = nstep;
         if (nstep != INIT_DONE) begin
            r = start_write(r, init_byte(nstep), 1'b0);
         end else begin
            r.phase = PH_IDLE;
         end
      end
      return r;
   endfunction

   status_type status;
   logic [7:0] cursor_byte;

   assign cursor_byte = ({1'b0, req.row, 6'b0} + {2'b0, req.column}) | CMD_SET_DDRAM;

   // One tick: resolve, take the request, run the phase, resolve again
   always_comb begin
      core_type s;
      s      = resolve(cur_ff, limit);
      status = ST_TICK;
      if (req.req_type != REQ_TICK) begin
         if (s.phase == PH_IDLE) begin
            status = ST_ACCEPTED;
            case (req.req_type)
               REQ_CHAR: s = start_write(s, req.data_byte, 1'b1);
               REQ_CMD:  s = start_write(s, req.data_byte, 1'b0);
               default:  s = start_write(s, cursor_byte, 1'b0);
            endcase
         end else begin
            status = ST_REJECTED;
         end
      end
      unique case (s.phase)
         PH_EHIGH: begin
            s.en = 1'b1;
            s    = count_up(s);
            if (s.cnt >= limit[CFG_E_HIGH_TIME]) begin
               s.bus   = s.pend;
               s.phase = PH_ELOW;
               s.cnt   = '0;
            end
         end
         PH_ELOW: begin
            s.en = 1'b0;
            s    = count_up(s);
            if (s.cnt >= limit[CFG_E_LOW_TIME]) begin
               s.cnt   = '0;
               s.phase = (s.step == INIT_DONE) ? PH_IDLE : PH_SETTLE;
            end
         end
         PH_POWERUP, PH_SETTLE: begin
            s.en = 1'b0;
            s    = count_up(s);
         end
         default: begin
         end
      endcase
      cur_in = resolve(s, limit);
   end

   // Advance the state once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.phase <= PH_POWERUP;
         cur_ff.step  <= '0;
         cur_ff.cnt   <= '0;
         cur_ff.pend  <= '0;
         cur_ff.rs    <= 1'b0;
         cur_ff.en    <= 1'b0;
         cur_ff.bus   <= '0;
      end else if (step_en) begin
         cur_ff <= cur_in;
      end
   end

   assign rsp.lcd_enable          = cur_in.en;
   assign rsp.lcd_register_select = cur_in.rs;
   assign rsp.lcd_bus             = cur_in.bus;
   assign rsp.busy_res            = (cur_in.phase != PH_IDLE);
   assign rsp.request_status      = status;

   // Not busy means the stored phase is idle
   assert property (@(posedge clock) disable iff (reset)
      (step_en && !rsp.busy_res) |=> (cur_ff.phase == PH_IDLE))
      else $error("lcdw_seq: busy low but phase not idle");

   // An accepted write drives enable high in the same tick
   assert property (@(posedge clock) disable iff (reset)
      (step_en && status == ST_ACCEPTED) |-> rsp.lcd_enable)
      else $error("lcdw_seq: accepted write without enable high");

   // The init step never goes back
   assert property (@(posedge clock) disable iff (reset)
      (step_en && !reset) |=> (cur_ff.step >= $past(cur_ff.step)))
      else $error("lcdw_seq: init step decreased");

endmodule
